// File: rtl/gsq_pkg.sv
// Package for the gesture stroke quantizer: result record, push record,
// direction and kind codes, request codes and register constants.
// No dependencies; every other file in rtl/ imports it.
package gsq_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_PRESS   = 2'd0;
	localparam logic [1:0] REQ_MOTION  = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_FINE    = 2'd0;
	localparam logic [1:0] KIND_ROUGH   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Direction codes.
	localparam logic [3:0] DIR_NONE      = 4'd0;
	localparam logic [3:0] DIR_LEFT      = 4'd1;
	localparam logic [3:0] DIR_RIGHT     = 4'd2;
	localparam logic [3:0] DIR_UP        = 4'd3;
	localparam logic [3:0] DIR_DOWN      = 4'd4;
	localparam logic [3:0] DIR_DOWNLEFT  = 4'd5;
	localparam logic [3:0] DIR_DOWNRIGHT = 4'd6;
	localparam logic [3:0] DIR_UPLEFT    = 4'd7;
	localparam logic [3:0] DIR_UPRIGHT   = 4'd8;

	// Register map: index taken from paddr[2].
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_SUPPRESS  = 1'b1;

	localparam int unsigned THR_BITS = 12;
	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 12'd30;
	localparam logic [2*THR_BITS-1:0] THRESHOLD_SQ_RESET =
		(2*THR_BITS)'(THRESHOLD_RESET) * (2*THR_BITS)'(THRESHOLD_RESET);

	// One result item as it leaves the block.
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] dir;
		logic [5:0] idx;
		logic [5:0] fine_total;
		logic [5:0] rough_total;
		logic       click;
		logic       last;
	} gsq_result_t;

	// Up to two results pushed into the result queue in one cycle.
	typedef struct packed {
		logic [1:0]  cnt;
		gsq_result_t first;
		gsq_result_t second;
	} gsq_push_t;

endpackage

// File: rtl/gesture_stroke_quantizer.sv
// Gesture stroke quantizer top level: input register, stroke trackers and
// APB-style register port. Depends on gsq_pkg and gsq_out_fifo.
//
// The block accepts one pointer event per cycle while in_ready is high. An
// accepted event sits in an input register while both trackers evaluate
// it against the reference points, and its results are registered into a
// four-entry result queue when the register empties. A motion event can
// give two results (fine stroke first) and a release gives one summary;
// the output port delivers one result per cycle while out_ready is high,
// so the sustained rate is one event per cycle as long as the events
// average at most one result each. An event is held in the input register
// while the queue has fewer than two free places. The squared-distance test
// uses two (COORD_BITS+1)-bit squarers, the widest logic between registers.
module gesture_stroke_quantizer
	import gsq_pkg::*;
#(
	parameter int unsigned MAX_STROKES = 63,
	parameter int unsigned COORD_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Event channel.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            result_kind,
	output logic [3:0]            direction,
	output logic [5:0]            stroke_index,
	output logic [5:0]            fine_total,
	output logic [5:0]            rough_total,
	output logic                  click_request,
	output logic                  last_of_run,
	// Register port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int unsigned CB  = COORD_BITS;
	localparam int unsigned CW  = $clog2(MAX_STROKES + 1);
	localparam int unsigned MW  = (CB + 1 > THR_BITS) ? CB + 1 : THR_BITS;
	localparam int unsigned SW  = (2*CB + 3 > 2*THR_BITS) ? 2*CB + 3 : 2*THR_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STROKES);

	// Registers and stroke state.
	logic [THR_BITS-1:0]   thr_q;
	logic [2*THR_BITS-1:0] thr_sq_q;
	logic                  suppress_q;
	logic                  armed_q;
	logic [CB-1:0]         fine_ref_x_q, fine_ref_y_q, rough_ref_x_q, rough_ref_y_q;
	logic [CW-1:0]         fine_cnt_q, rough_cnt_q;
	logic [3:0]            fine_last_q, rough_last_q;

	// Input register.
	logic                  valid_s1;
	logic [1:0]            req_s1;
	logic [CB-1:0]         x_s1, y_s1;

	logic                  room;
	logic                  take_s1;
	logic                  cfg_write;
	gsq_push_t             push;
	gsq_result_t           head;

	// Tracker signals.
	logic signed [CB:0]    f_dx, f_dy, r_dx, r_dy;
	logic [CB:0]           f_ax, f_ay, r_ax, r_ay;
	logic [2*CB+1:0]       r_sx, r_sy;
	logic [2*CB+2:0]       r_sum;
	logic                  fine_hit, rough_hit;
	logic [3:0]            f_dir, r_dir;
	logic                  f_app, r_app;
	logic [CW-1:0]         fine_cnt_nx, rough_cnt_nx;
	gsq_result_t           res_fine, res_rough, res_sum;

	function automatic logic [CB:0] mag_of(input logic signed [CB:0] d);
		return d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
	endfunction

	// Eight-way direction: diagonal unless one axis exceeds three times the other.
	function automatic logic [3:0] fine_dir_of(input logic signed [CB:0] dx,
		input logic signed [CB:0] dy, input logic [CB:0] ax, input logic [CB:0] ay);
		logic [CB+2:0] ax3;
		logic [CB+2:0] ay3;
		logic          straight;
		logic [3:0]    d;
		ax3 = (CB+3)'(ax) + (CB+3)'({ax, 1'b0});
		ay3 = (CB+3)'(ay) + (CB+3)'({ay, 1'b0});
		straight = ((CB+3)'(ax) > ay3) || ((CB+3)'(ay) > ax3);
		if (dx == '0 && dy == '0) begin
			d = DIR_NONE;
		end else if (straight) begin
			if (ax > ay) begin
				d = dx[CB] ? DIR_LEFT : DIR_RIGHT;
			end else begin
				d = dy[CB] ? DIR_UP : DIR_DOWN;
			end
		end else if (dy[CB]) begin
			d = dx[CB] ? DIR_UPLEFT : DIR_UPRIGHT;
		end else begin
			d = dx[CB] ? DIR_DOWNLEFT : DIR_DOWNRIGHT;
		end
		return d;
	endfunction

	// Four-way direction: the larger axis wins, ties go horizontal.
	function automatic logic [3:0] rough_dir_of(input logic signed [CB:0] dx,
		input logic signed [CB:0] dy, input logic [CB:0] ax, input logic [CB:0] ay);
		logic [3:0] d;
		if (ay > ax) begin
			d = dy[CB] ? DIR_UP : DIR_DOWN;
		end else if (!dx[CB] && dx != '0) begin
			d = DIR_RIGHT;
		end else begin
			d = DIR_LEFT;
		end
		return d;
	endfunction

	// Input handshake: the register empties whenever the queue has room.
	assign take_s1  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_type;
			x_s1   <= pos_x;
			y_s1   <= pos_y;
		end
	end

	// Fine tracker: per-axis threshold test and eight-way quantisation.
	assign f_dx = $signed({x_s1[CB-1], x_s1}) - $signed({fine_ref_x_q[CB-1], fine_ref_x_q});
	assign f_dy = $signed({y_s1[CB-1], y_s1}) - $signed({fine_ref_y_q[CB-1], fine_ref_y_q});
	assign f_ax = mag_of(f_dx);
	assign f_ay = mag_of(f_dy);
	assign fine_hit = (MW'(f_ax) > MW'(thr_q)) || (MW'(f_ay) > MW'(thr_q));
	assign f_dir = fine_dir_of(f_dx, f_dy, f_ax, f_ay);

	// Rough tracker: squared distance against the squared threshold.
	assign r_dx  = $signed({x_s1[CB-1], x_s1}) - $signed({rough_ref_x_q[CB-1], rough_ref_x_q});
	assign r_dy  = $signed({y_s1[CB-1], y_s1}) - $signed({rough_ref_y_q[CB-1], rough_ref_y_q});
	assign r_ax  = mag_of(r_dx);
	assign r_ay  = mag_of(r_dy);
	assign r_sx  = (2*CB+2)'(r_ax) * (2*CB+2)'(r_ax);
	assign r_sy  = (2*CB+2)'(r_ay) * (2*CB+2)'(r_ay);
	assign r_sum = (2*CB+3)'(r_sx) + (2*CB+3)'(r_sy);
	assign rough_hit = SW'(r_sum) > SW'(thr_sq_q);
	assign r_dir = rough_dir_of(r_dx, r_dy, r_ax, r_ay);

	// Append decisions: repeated directions and full sequences are dropped.
	always_comb begin
		f_app = armed_q && (req_s1 == REQ_MOTION) && fine_hit
			&& !(fine_cnt_q != '0 && fine_last_q == f_dir) && (fine_cnt_q < MAX_CNT);
		r_app = armed_q && (req_s1 == REQ_MOTION) && rough_hit
			&& !(rough_cnt_q != '0 && rough_last_q == r_dir) && (rough_cnt_q < MAX_CNT);
		fine_cnt_nx  = fine_cnt_q + CW'(f_app);
		rough_cnt_nx = rough_cnt_q + CW'(r_app);
	end

	// Result records.
	always_comb begin
		res_fine = '{kind: KIND_FINE, dir: f_dir, idx: 6'(fine_cnt_q),
			fine_total: 6'(fine_cnt_nx), rough_total: 6'(rough_cnt_q),
			click: 1'b0, last: !r_app};
		res_rough = '{kind: KIND_ROUGH, dir: r_dir, idx: 6'(rough_cnt_q),
			fine_total: 6'(fine_cnt_nx), rough_total: 6'(rough_cnt_nx),
			click: 1'b0, last: 1'b1};
		res_sum = '{kind: KIND_SUMMARY, dir: DIR_NONE, idx: 6'd0,
			fine_total: 6'(fine_cnt_q), rough_total: 6'(rough_cnt_q),
			click: (fine_cnt_q == '0) && (rough_cnt_q == '0) && !suppress_q,
			last: 1'b1};
	end

	// Queue push, packed so that the first present result comes first.
	always_comb begin
		push.cnt    = 2'd0;
		push.first  = res_sum;
		push.second = res_rough;
		if (take_s1) begin
			unique case (req_s1)
				REQ_MOTION: begin
					push.cnt   = 2'(f_app) + 2'(r_app);
					push.first = f_app ? res_fine : res_rough;
				end
				REQ_RELEASE: begin
					push.cnt = 2'd1;
				end
				default: begin
					push.cnt = 2'd0;
				end
			endcase
		end
	end

	// Stroke state update when the held event is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			fine_ref_x_q  <= '0;
			fine_ref_y_q  <= '0;
			rough_ref_x_q <= '0;
			rough_ref_y_q <= '0;
			fine_cnt_q    <= '0;
			rough_cnt_q   <= '0;
			fine_last_q   <= DIR_NONE;
			rough_last_q  <= DIR_NONE;
		end else if (take_s1) begin
			unique case (req_s1)
				REQ_PRESS: begin
					armed_q       <= 1'b1;
					fine_ref_x_q  <= x_s1;
					fine_ref_y_q  <= y_s1;
					rough_ref_x_q <= x_s1;
					rough_ref_y_q <= y_s1;
					fine_cnt_q    <= '0;
					rough_cnt_q   <= '0;
					fine_last_q   <= DIR_NONE;
					rough_last_q  <= DIR_NONE;
				end
				REQ_MOTION: begin
					if (armed_q && fine_hit) begin
						fine_ref_x_q <= x_s1;
						fine_ref_y_q <= y_s1;
					end
					if (armed_q && rough_hit) begin
						rough_ref_x_q <= x_s1;
						rough_ref_y_q <= y_s1;
					end
					if (f_app) begin
						fine_last_q <= f_dir;
					end
					if (r_app) begin
						rough_last_q <= r_dir;
					end
					fine_cnt_q  <= fine_cnt_nx;
					rough_cnt_q <= rough_cnt_nx;
				end
				REQ_RELEASE: begin
					armed_q <= 1'b0;
				end
				default: begin
					armed_q <= armed_q;
				end
			endcase
		end
	end

	// Register port: write in the access phase, read data decoded from paddr.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THRESHOLD_RESET;
			thr_sq_q   <= THRESHOLD_SQ_RESET;
			suppress_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_THRESHOLD: begin
					thr_q    <= pwdata[THR_BITS-1:0];
					thr_sq_q <= (2*THR_BITS)'(pwdata[THR_BITS-1:0])
						* (2*THR_BITS)'(pwdata[THR_BITS-1:0]);
				end
				default: begin
					suppress_q <= pwdata[0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = 32'(thr_q);
			default:       prdata = 32'(suppress_q);
		endcase
	end

	// Result queue and output fields.
	gsq_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign result_kind   = head.kind;
	assign direction     = head.dir;
	assign stroke_index  = head.idx;
	assign fine_total    = head.fine_total;
	assign rough_total   = head.rough_total;
	assign click_request = head.click;
	assign last_of_run   = head.last;

	// A consumed release always leaves the result queue non-empty.
	a_release_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && req_s1 == REQ_RELEASE |=> out_valid)
		else $error("release transfer left no result queued");

	// Stroke counts never pass the sequence limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fine_cnt_q <= MAX_CNT && rough_cnt_q <= MAX_CNT)
		else $error("stroke count beyond limit");

	// A press arms the trackers with empty sequences.
	a_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && req_s1 == REQ_PRESS
		|=> armed_q && fine_cnt_q == '0 && rough_cnt_q == '0)
		else $error("press did not clear the stroke sequences");

endmodule

// File: rtl/gsq_out_fifo.sv
// Four-entry result queue of the gesture stroke quantizer: takes up to two
// results a cycle and delivers one a cycle, while out_ready is high, on a valid/ready port.
// Depends on gsq_pkg.
module gsq_out_fifo
	import gsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  gsq_push_t   push,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output gsq_result_t head
);

	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;
	gsq_result_t mem_q [4];
	logic        pop;

	// Space for a full pair of results is required before the producer may push.
	assign room      = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	// Storage: the first result at the write pointer, the second just after it.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.second;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push.cnt) - 3'(pop);
		end
	end

endmodule
